// File: design/crm_pkg.sv
// Shared types and constants for the chunked raw moments block.
package crm_pkg;

   localparam int IN_W       = 12;
   localparam int SUM_W      = 58;
   localparam int VAL_W      = 46;
   localparam int CNT_W      = 16;
   localparam int LEN_W      = 13;
   localparam int SKIP_W     = 16;
   localparam int MASK_W     = 4;
   localparam int ORD_W      = 3;
   localparam int POS_W      = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POWER_MASK   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POWER,
      ST_SEL,
      ST_DIVW,
      ST_EMIT,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic load;
      logic acc;
      logic fill_inc;
      logic div_start;
      logic out_load;
      logic chunk_clear;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic chunk_done;
      logic sel_hit;
      logic div_done;
   } status_type;

endpackage

// File: design/crm_div.sv
// Iterative signed divider: one quotient bit per cycle, truncating toward zero.
module crm_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [crm_pkg::SUM_W-1:0]    dividend,
   input  logic        [crm_pkg::LEN_W-1:0]    divisor,
   output logic                                done,
   output logic        [crm_pkg::VAL_W-1:0]    quotient
);
   import crm_pkg::*;

   localparam int CW = $clog2(SUM_W);

   logic             busy_ff;
   logic             done_ff;
   logic [CW-1:0]    cnt_ff;
   logic [SUM_W-1:0] quo_ff;
   logic [LEN_W-1:0] rem_ff;
   logic [LEN_W-1:0] den_ff;
   logic             neg_ff;
   logic [LEN_W:0]   trial;
   logic             fits;
   logic [LEN_W:0]   diff;
   logic [SUM_W-1:0] signed_quo;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(SUM_W - 1);
            rem_ff  <= '0;
            den_ff  <= divisor;
            neg_ff  <= dividend[SUM_W-1];
            quo_ff  <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
            quo_ff <= {quo_ff[SUM_W-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign signed_quo = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign quotient   = signed_quo[VAL_W-1:0];
   assign done       = done_ff;

endmodule

// File: design/crm_dp.sv
// Datapath: configuration, row and chunk counters, power sums and result register.
module crm_dp #(
   parameter int MAX_POWER   = 4,
   parameter int MAX_CHUNK   = 4096,
   parameter int SAMPLE_BITS = 12,
   parameter int KW          = 2
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [crm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [crm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [crm_pkg::IN_W-1:0]           req_sample,
   input  logic                               req_row_start,
   input  crm_pkg::cmd_type                   cmd,
   input  logic [KW-1:0]                      k,
   output crm_pkg::status_type                status,
   output logic [crm_pkg::ORD_W-1:0]          rsp_power_order,
   output logic [crm_pkg::VAL_W-1:0]          rsp_moment_value,
   output logic [crm_pkg::CNT_W-1:0]          rsp_chunk_number,
   output logic                               rsp_last
);
   import crm_pkg::*;

   localparam int PW = SAMPLE_BITS * MAX_POWER;

   logic [SKIP_W-1:0]            skip_ff;
   logic [LEN_W-1:0]             len_ff;
   logic [MASK_W-1:0]            mask_ff;
   logic [POS_W-1:0]             pos_ff;
   logic [LEN_W-1:0]             fill_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic signed [SUM_W-1:0]      sums_ff [MAX_POWER];
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic signed [PW-1:0]         p_ff;
   logic [ORD_W-1:0]             ord_ff;
   logic [VAL_W-1:0]             val_ff;
   logic [CNT_W-1:0]             num_ff;
   logic                         last_ff;

   logic signed [SAMPLE_BITS-1:0]     x_in;
   logic signed [PW+SAMPLE_BITS-1:0]  prod;
   logic [POS_W-1:0]                  pos_eff;
   logic [LEN_W-1:0]                  len_eff;
   logic [LEN_W-1:0]                  fill_next;
   logic [MAX_POWER-1:0]              mask_used;
   logic [MAX_POWER-1:0]              mask_rest;
   logic                              is_last;
   logic                              div_done;
   logic [VAL_W-1:0]                  quotient;

   assign x_in    = req_sample[SAMPLE_BITS-1:0];
   assign prod    = p_ff * x_ff;
   assign pos_eff = req_row_start ? '0 : pos_ff;

   always_comb begin
      if (len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_ff > LEN_W'(MAX_CHUNK)) begin
         len_eff = LEN_W'(MAX_CHUNK);
      end else begin
         len_eff = len_ff;
      end
   end

   assign fill_next = fill_ff + 1'b1;
   assign mask_used = mask_ff[MAX_POWER-1:0];
   assign mask_rest = mask_used >> k;
   assign is_last   = (mask_rest >> 1) == '0;

   assign status.skip       = pos_eff < {1'b0, skip_ff};
   assign status.chunk_done = fill_next >= len_eff;
   assign status.sel_hit    = mask_used[k];
   assign status.div_done   = div_done;

   crm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sums_ff[k]),
      .divisor  (len_eff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= '0;
         len_ff  <= LEN_W'(1);
         mask_ff <= MASK_W'(1);
         pos_ff  <= '0;
         fill_ff <= '0;
         cnt_ff  <= '0;
         for (int i = 0; i < MAX_POWER; i++) begin
            sums_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_SKIP_COUNT:   skip_ff <= csr_wdata[SKIP_W-1:0];
               CSR_CHUNK_LENGTH: len_ff  <= csr_wdata[LEN_W-1:0];
               CSR_POWER_MASK:   mask_ff <= csr_wdata[MASK_W-1:0];
               default: ;
            endcase
         end
         if (cmd.load) begin
            x_ff <= x_in;
            p_ff <= PW'(x_in);
            pos_ff <= status.skip ? (pos_eff + 1'b1) : pos_eff;
            if (req_row_start) begin
               fill_ff <= '0;
               cnt_ff  <= '0;
               for (int i = 0; i < MAX_POWER; i++) begin
                  sums_ff[i] <= '0;
               end
            end
         end
         if (cmd.acc) begin
            sums_ff[k] <= sums_ff[k] + SUM_W'(p_ff);
            p_ff       <= prod[PW-1:0];
         end
         if (cmd.fill_inc) begin
            fill_ff <= fill_next;
         end
         if (cmd.chunk_clear) begin
            fill_ff <= '0;
            if (cnt_ff != '1) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            for (int i = 0; i < MAX_POWER; i++) begin
               sums_ff[i] <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         ord_ff  <= ORD_W'(k) + 1'b1;
         val_ff  <= quotient;
         num_ff  <= cnt_ff;
         last_ff <= is_last;
      end
   end

   assign rsp_power_order  = ord_ff;
   assign rsp_moment_value = val_ff;
   assign rsp_chunk_number = num_ff;
   assign rsp_last         = last_ff;

endmodule

// File: design/crm_ctrl.sv
// Controller: sequences accept, power accumulation, chunk divisions and result delivery.
module crm_ctrl #(
   parameter int MAX_POWER = 4,
   parameter int KW        = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 rsp_ready,
   input  crm_pkg::status_type  status,
   output logic                 req_ready,
   output logic                 rsp_valid,
   output crm_pkg::cmd_type     cmd,
   output logic [KW-1:0]        k
);
   import crm_pkg::*;

   localparam logic [KW-1:0] KLAST = KW'(MAX_POWER - 1);

   state_type     state_ff, state_in;
   logic [KW-1:0] k_ff, k_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               k_in     = '0;
               if (!status.skip) begin
                  state_in = ST_POWER;
               end
            end
         end
         ST_POWER: begin
            cmd.acc = 1'b1;
            if (k_ff == KLAST) begin
               cmd.fill_inc = 1'b1;
               k_in         = '0;
               state_in     = status.chunk_done ? ST_SEL : ST_IDLE;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_SEL: begin
            if (status.sel_hit) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVW;
            end else if (k_ff == KLAST) begin
               state_in = ST_CLEAR;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DIVW: begin
            if (status.div_done) begin
               cmd.out_load = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (k_ff == KLAST) begin
                  state_in = ST_CLEAR;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_SEL;
               end
            end
         end
         ST_CLEAR: begin
            cmd.chunk_clear = 1'b1;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign k = k_ff;

endmodule

// File: design/chunked_raw_moments_core.sv
// Top level of the chunked raw moments block: controller, datapath and divider.
//
// This block takes one signed sample per request, with a row start flag, skips the first
// skip_count samples of each row and groups later samples into chunks of chunk_length.
// It works on one request at a time. A skipped sample only advances the row position.
// Any other sample is accepted and then stepped through the powers, since a single
// shared multiplier raises the sample to the next power while the previous power is added
// into its exact 58-bit sum. When a chunk completes, each power selected in power_mask is
// divided by the chunk length in a bit-serial divider, and the mean is offered on the
// response channel; the block waits for each response to be taken before starting the
// next division. The ST_CLEAR state then clears the sums. Responses come in rising power
// order, and rsp_last marks the final one of a chunk; an empty mask completes the chunk
// silently. Configuration writes are taken at any time but are meant to be made while
// the block is idle.
module chunked_raw_moments_core #(
   parameter int MAX_POWER   = 4,
   parameter int MAX_CHUNK   = 4096,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [crm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [crm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [crm_pkg::IN_W-1:0]           req_sample,
   input  logic                               req_row_start,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [crm_pkg::ORD_W-1:0]          rsp_power_order,
   output logic [crm_pkg::VAL_W-1:0]          rsp_moment_value,
   output logic [crm_pkg::CNT_W-1:0]          rsp_chunk_number,
   output logic                               rsp_last
);
   import crm_pkg::*;

   // The power index needs at least one bit even with a single power.
   localparam int KW = (MAX_POWER > 1) ? $clog2(MAX_POWER) : 1;

   cmd_type       cmd;
   status_type    status;
   logic [KW-1:0] k;

   crm_ctrl #(
      .MAX_POWER (MAX_POWER),
      .KW        (KW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .k         (k)
   );

   crm_dp #(
      .MAX_POWER   (MAX_POWER),
      .MAX_CHUNK   (MAX_CHUNK),
      .SAMPLE_BITS (SAMPLE_BITS),
      .KW          (KW)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_sample       (req_sample),
      .req_row_start    (req_row_start),
      .cmd              (cmd),
      .k                (k),
      .status           (status),
      .rsp_power_order  (rsp_power_order),
      .rsp_moment_value (rsp_moment_value),
      .rsp_chunk_number (rsp_chunk_number),
      .rsp_last         (rsp_last)
   );

endmodule

// File: design/crm_checker.sv
// Port-level checks for the chunked raw moments block, bound to the top level.
module crm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [crm_pkg::ORD_W-1:0]     rsp_power_order,
   input logic [crm_pkg::VAL_W-1:0]     rsp_moment_value,
   input logic [crm_pkg::CNT_W-1:0]     rsp_chunk_number,
   input logic                          rsp_last
);
   import crm_pkg::*;

   // A stalled response holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_moment_value)
         && $stable(rsp_power_order) && $stable(rsp_chunk_number) && $stable(rsp_last))
      else $error("stalled response changed");

   // No request is taken while a response is pending.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready during response");

   // More responses of the same chunk follow before the next request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> !req_ready && !rsp_valid)
      else $error("chunk ended early");

   // A response of the highest order, 4, is always the last of its chunk.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |-> rsp_power_order != ORD_W'(4))
      else $error("highest order not last");

endmodule

bind chunked_raw_moments_core crm_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_power_order  (rsp_power_order),
   .rsp_moment_value (rsp_moment_value),
   .rsp_chunk_number (rsp_chunk_number),
   .rsp_last         (rsp_last)
);

// File: bench/chunked_raw_moments_core_test.sv
// Self-checking testbench for the chunked raw moments block.
module chunked_raw_moments_core_test;
   import crm_pkg::*;

   typedef struct {
      logic [IN_W-1:0] sample;
      logic            row_start;
   } sample_req_t;

   typedef struct {
      logic [ORD_W-1:0] order;
      logic [VAL_W-1:0] value;
      logic [CNT_W-1:0] chunk;
      logic             last;
   } moment_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_SKIP_COUNT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [IN_W-1:0]       req_sample = '0;
   logic                  req_row_start = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [ORD_W-1:0]      rsp_power_order;
   logic [VAL_W-1:0]      rsp_moment_value;
   logic [CNT_W-1:0]      rsp_chunk_number;
   logic                  rsp_last;

   chunked_raw_moments_core dut (.*);

   always #5 clock = ~clock;

   // Pending requests, filled by the stimulus block and drained by the driver.
   sample_req_t pending_reqs[$];
   // Expected moments, oldest first.
   moment_t     expected_moments[$];

   // Predictor state and its copy of the registers.
   logic [SKIP_W-1:0] pred_skip;
   logic [LEN_W-1:0]  pred_len;
   logic [MASK_W-1:0] pred_mask;
   longint            pred_sums[4];
   int unsigned       pred_pos, pred_fill, pred_chunk;

   int  error_count = 0;
   int  idle_cycles = 0;
   bit  stall_hold = 1'b0;   // Long receiver hold-off, set by the stimulus block.
   bit  send_pause = 1'b0;   // Sender pause, set by the stimulus block.
   int  burst_left = 0, gap_left = 0;
   int  stall_mode = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // Advance the predictor by one accepted request and queue the moments it causes.
   task automatic predict_moments(input sample_req_t r);
      longint x, p;
      int unsigned len, cnt, n;
      moment_t m;
      x = longint'($signed(r.sample));
      if (r.row_start) begin
         pred_pos = 0; pred_fill = 0; pred_chunk = 0;
         for (int k = 0; k < 4; k++) pred_sums[k] = 0;
      end
      if (pred_pos < pred_skip) begin
         pred_pos++;
         return;
      end
      p = 1;
      for (int k = 0; k < 4; k++) begin
         p = p * x;
         pred_sums[k] += p;
      end
      pred_fill++;
      len = pred_len;
      if (len == 0) len = 1;
      if (len > 4096) len = 4096;
      if (pred_fill < len) return;
      cnt = 0;
      for (int k = 0; k < 4; k++) if (pred_mask[k]) cnt++;
      n = 0;
      for (int k = 0; k < 4; k++) begin
         if (pred_mask[k]) begin
            m.order = ORD_W'(k + 1);
            m.value = VAL_W'(pred_sums[k] / longint'(len));
            m.chunk = CNT_W'(pred_chunk);
            m.last  = (n == cnt - 1);
            expected_moments.push_back(m);
            n++;
         end
      end
      for (int k = 0; k < 4; k++) pred_sums[k] = 0;
      pred_fill = 0;
      if (pred_chunk < 16'hFFFF) pred_chunk++;
   endtask

   // Driver: bursts of requests with random gaps. Valid holds until accepted.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) predict_moments('{req_sample, req_row_start});
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !send_pause) begin
               sample_req_t r;
               r = pending_reqs.pop_front();
               req_valid     <= 1'b1;
               req_sample    <= r.sample;
               req_row_start <= r.row_start;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares every accepted response with the oldest expectation
   // and drives the receiver's stall pattern.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_moments.size() == 0) begin
               report_mismatch("unexpected response order", rsp_power_order, 0);
            end else begin
               moment_t e;
               e = expected_moments.pop_front();
               if (rsp_power_order !== e.order)
                  report_mismatch("power_order", rsp_power_order, e.order);
               if (rsp_moment_value !== e.value)
                  report_mismatch("moment_value", $signed(rsp_moment_value), $signed(e.value));
               if (rsp_chunk_number !== e.chunk)
                  report_mismatch("chunk_number", rsp_chunk_number, e.chunk);
               if (rsp_last !== e.last)
                  report_mismatch("last", rsp_last, e.last);
            end
         end
         if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_ready <= !stall_hold;
            1: rsp_ready <= !stall_hold && ($urandom_range(0, 3) != 0);
            default: rsp_ready <= !stall_hold && ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Watchdog: a long span with no handshake on either side ends the run.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("chunked_raw_moments_core_test failed");
         $finish;
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      // The predictor applies the write as the block does, masked to width.
      case (idx)
         CSR_SKIP_COUNT:   pred_skip = val;
         CSR_CHUNK_LENGTH: pred_len  = val[LEN_W-1:0];
         CSR_POWER_MASK:   pred_mask = val[MASK_W-1:0];
         default: ;
      endcase
   endtask

   // Wait until every request is sent and every moment has come back, then let
   // the block finish any silent chunk.
   task automatic drain;
      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_moments.size() == 0);
      repeat (300) @(posedge clock);
   endtask

   task automatic add_req(input int s, input bit rs);
      pending_reqs.push_back('{IN_W'(s), rs});
   endtask

   // One random phase: rows of random length with random samples.
   task automatic random_rows(input int n_items, input int extreme_pct);
      int s;
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(0, 99) < extreme_pct)
            s = $urandom_range(0, 1) ? 2047 : -2048;
         else
            s = $urandom_range(0, 4095);
         add_req(s, (i == 0) || ($urandom_range(0, 14) == 0));
      end
   endtask

   initial begin
      pred_skip = 0; pred_len = 1; pred_mask = 1;
      pred_pos = 0; pred_fill = 0; pred_chunk = 0;
      for (int k = 0; k < 4; k++) pred_sums[k] = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part under reset settings: extremes of the sample, one per chunk.
      add_req(2047, 1); add_req(-2048, 0); add_req(0, 0); add_req(-1, 0); add_req(1, 1);
      drain();

      // All powers, chunks of two, skip of one; extremes and a dropped partial chunk.
      write_csr(CSR_SKIP_COUNT, 16'd1);
      write_csr(CSR_CHUNK_LENGTH, 16'd2);
      write_csr(CSR_POWER_MASK, 16'd15);
      add_req(5, 1); add_req(-2048, 0); add_req(-2048, 0); add_req(2047, 0);
      add_req(-2048, 0); add_req(7, 0); add_req(3, 1); add_req(-3, 0); add_req(-5, 0);
      drain();

      // Empty mask: chunks complete silently but still advance the counter.
      write_csr(CSR_POWER_MASK, 16'd0);
      add_req(9, 1); add_req(9, 0); add_req(9, 0);
      drain();
      // Unused upper mask bits, with a new mask set between chunks.
      write_csr(CSR_POWER_MASK, 16'hFFFA);
      add_req(-7, 0); add_req(11, 0);
      drain();

      // Zero length acts as one; then shrink length in the middle of a chunk.
      write_csr(CSR_CHUNK_LENGTH, 16'd0);
      write_csr(CSR_SKIP_COUNT, 16'd0);
      add_req(-2048, 1); add_req(100, 0);
      drain();
      write_csr(CSR_CHUNK_LENGTH, 16'd5);
      add_req(3, 1); add_req(4, 0); add_req(5, 0);
      drain();
      write_csr(CSR_CHUNK_LENGTH, 16'd2);
      add_req(6, 0);
      drain();

      // Random phase: small chunks, all powers; long receiver hold-off so the
      // block backs up and stalls its input.
      write_csr(CSR_CHUNK_LENGTH, 16'd1);
      write_csr(CSR_POWER_MASK, 16'd15);
      write_csr(CSR_SKIP_COUNT, 16'd2);
      random_rows(90, 10);
      stall_hold = 1'b1;
      repeat (600) @(posedge clock);
      stall_hold = 1'b0;
      // The sender pauses until every expected moment has come.
      send_pause = 1'b1;
      wait (expected_moments.size() == 0);
      send_pause = 1'b0;
      drain();

      // Random phase with a random mid-size setting.
      write_csr(CSR_SKIP_COUNT, 16'($urandom_range(0, 3)));
      write_csr(CSR_CHUNK_LENGTH, 16'($urandom_range(2, 4)));
      write_csr(CSR_POWER_MASK, 16'($urandom_range(0, 15)));
      random_rows(80, 5);
      drain();

      // Oversized length: a short row of extreme samples never fills the chunk,
      // and its partial sums are dropped when the next row starts.
      write_csr(CSR_SKIP_COUNT, 16'd0);
      write_csr(CSR_CHUNK_LENGTH, 16'h1FFF);
      write_csr(CSR_POWER_MASK, 16'd15);
      for (int i = 0; i < 8; i++) add_req((i % 2) ? 2047 : -2048, i == 0);
      drain();

      // Largest skip: the whole row is ignored, then a new row.
      write_csr(CSR_SKIP_COUNT, 16'hFFFF);
      write_csr(CSR_CHUNK_LENGTH, 16'd1);
      random_rows(6, 20);
      drain();

      // Final random phase with chunks of three and powers one and four.
      write_csr(CSR_SKIP_COUNT, 16'd0);
      write_csr(CSR_CHUNK_LENGTH, 16'd3);
      write_csr(CSR_POWER_MASK, 16'd9);
      random_rows(60, 15);
      drain();

      if (error_count == 0) $display("chunked_raw_moments_core_test passed");
      else $display("chunked_raw_moments_core_test failed");
      $finish;
   end

endmodule
